FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the RTL. Define ASSERT_OFF to drop
// every check from the build.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at each rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on the following clock edge.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

FILE: rtl/b2bcd_pkg.sv
// ---------------------------------------------------------------------------
// b2bcd_pkg
// Widths, types and constants shared by the binary to BCD converter.
// ---------------------------------------------------------------------------
package b2bcd_pkg;

  // Width of the binary input port
  localparam int VALUE_WIDTH = 32;
  // Default width of the integer actually converted
  localparam int DEFAULT_INPUT_WIDTH = 32;
  // One BCD digit
  localparam int DIGIT_BITS = 4;
  // Digit cells in the chain
  localparam int NUM_DIGITS = 10;
  // Width of the packed BCD result
  localparam int OUT_WIDTH = 38;

  typedef logic [DIGIT_BITS-1:0] digit_t;

  // Control handed from the sequencer to every digit cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/binary_to_bcd_converter.sv
// Sequence: after the accepting edge the sequencer shifts the digit chain once
// per input bit in ST_SHIFT, then enters ST_DONE, where done marks the result.
// A new start is taken only back in idle, after done; busy stays high
// from the accepting edge through the done cycle.
// Reset: synchronous, active high; returns the sequencer to idle.
// Results cannot be stalled: done is a single-cycle strobe.
// ---------------------------------------------------------------------------
// binary_to_bcd_converter
// Converts a two's complement integer to packed BCD with a chain of digit
// cells run by a bit-serial sequencer. Zero or negative input gives zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_to_bcd_converter #(
  parameter int INPUT_WIDTH = b2bcd_pkg::DEFAULT_INPUT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [b2bcd_pkg::VALUE_WIDTH-1:0] binary_value,
  output logic                                busy,
  output logic                                done,
  output logic [b2bcd_pkg::OUT_WIDTH-1:0]     bcd_digits
);

  localparam int CNT_W = $clog2(INPUT_WIDTH);
  localparam int BUS_W = b2bcd_pkg::NUM_DIGITS * b2bcd_pkg::DIGIT_BITS;
  // Wider inputs may carry past the top digit; those digits are dropped
  localparam bit WIDE_IN = (INPUT_WIDTH > b2bcd_pkg::VALUE_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [INPUT_WIDTH-1:0]     shreg;
  logic [INPUT_WIDTH-1:0]     shreg_next;
  logic [INPUT_WIDTH-1:0]     value_in;
  logic                       accept;
  b2bcd_pkg::cell_ctrl_t      ctrl;
  logic [b2bcd_pkg::NUM_DIGITS-1:0] carry;
  logic                       carry_top;
  logic [BUS_W-1:0]           digit_bus;

  // Take the low INPUT_WIDTH bits, sign extending for wider conversions
  generate
    if (INPUT_WIDTH <= b2bcd_pkg::VALUE_WIDTH) begin : g_narrow
      assign value_in = binary_value[INPUT_WIDTH-1:0];
    end else begin : g_wide
      assign value_in = {{(INPUT_WIDTH - b2bcd_pkg::VALUE_WIDTH){binary_value[
                          b2bcd_pkg::VALUE_WIDTH-1]}}, binary_value};
    end
  endgenerate

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);

  // Sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    shreg_next = shreg;
    ctrl.clear = 1'b0;
    ctrl.shift = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctrl.clear = 1'b1;
          count_next = '0;
          // Negative input converts as zero
          shreg_next = value_in[INPUT_WIDTH-1] ? '0 : value_in;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        ctrl.shift = 1'b1;
        shreg_next = {shreg[INPUT_WIDTH-2:0], 1'b0};
        count_next = count + CNT_W'(1);
        if (count == CNT_W'(INPUT_WIDTH - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    count <= count_next;
    shreg <= shreg_next;
  end

  // Digit chain, least significant digit first; the top carry falls off
  assign carry[0] = shreg[INPUT_WIDTH-1];

  genvar gi;
  generate
    for (gi = 0; gi < b2bcd_pkg::NUM_DIGITS; gi++) begin : g_cell
      if (gi < b2bcd_pkg::NUM_DIGITS - 1) begin : g_mid
        b2bcd_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .carry_in  (carry[gi]),
          .carry_out (carry[gi+1]),
          .digit     (digit_bus[gi*b2bcd_pkg::DIGIT_BITS +: b2bcd_pkg::DIGIT_BITS])
        );
      end else begin : g_top
        b2bcd_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .carry_in  (carry[gi]),
          .carry_out (carry_top),
          .digit     (digit_bus[gi*b2bcd_pkg::DIGIT_BITS +: b2bcd_pkg::DIGIT_BITS])
        );
      end
    end
  endgenerate

  assign bcd_digits = digit_bus[b2bcd_pkg::OUT_WIDTH-1:0];

  // Checks
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "busy not raised after accept")
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "done held over two cycles")
  `ASSERT_NEXT(a_done_idle, clk, rst, done, !busy, "not idle after done")
  `ASSERT_CLK(a_done_shift, clk, rst, done |-> $past(state) == ST_SHIFT, "done without a shift pass")
  `ASSERT_NEXT(a_neg_zero, clk, rst, accept && value_in[INPUT_WIDTH-1], shreg == '0, "negative input not cleared")
  `ASSERT_CLK(a_top_carry, clk, rst, !ctrl.shift || WIDE_IN || !carry_top, "top digit overflow")

endmodule

FILE: rtl/b2bcd_cell.sv
// ---------------------------------------------------------------------------
// b2bcd_cell
// One decimal digit of the double-dabble chain: add three when the digit is
// five or more, then shift left, taking one bit from the lower neighbor and
// handing the top bit to the upper neighbor.
// ---------------------------------------------------------------------------
module b2bcd_cell (
  input  logic                  clk,
  input  b2bcd_pkg::cell_ctrl_t ctrl,
  input  logic                  carry_in,
  output logic                  carry_out,
  output b2bcd_pkg::digit_t     digit
);

  b2bcd_pkg::digit_t adjusted;
  b2bcd_pkg::digit_t digit_next;

  // Correction so the digit doubles cleanly into the next decade
  always_comb begin
    if (digit >= b2bcd_pkg::digit_t'(5)) begin
      adjusted = digit + b2bcd_pkg::digit_t'(3);
    end else begin
      adjusted = digit;
    end
  end

  assign carry_out = adjusted[b2bcd_pkg::DIGIT_BITS-1];

  // Next digit value
  always_comb begin
    if (ctrl.clear) begin
      digit_next = '0;
    end else if (ctrl.shift) begin
      digit_next = {adjusted[b2bcd_pkg::DIGIT_BITS-2:0], carry_in};
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule
